/* rtl/stc27_pkg.sv */
package stc27_pkg;

  localparam int MAX_ROW   = 256;
  localparam int MAX_PLANE = 65536;
  localparam int MIN_ROW   = 3;
  localparam int MIN_PLANE = 9;
  localparam int HIST_DEPTH = 2 * MAX_PLANE + 2 * MAX_ROW + 3;
  localparam int ADDR_W = $clog2(HIST_DEPTH);
  localparam int TAPS = 27;
  localparam int ROWS = 9;
  localparam int MEM_ROWS = 8;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_PLANE_SIZE = 1'b1;

  typedef logic [31:0] word_t;
  typedef word_t [TAPS-1:0] taps_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] center_index;
  } tag_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] center_index;
    logic [31:0] result;
    logic        saturated;
  } res_t;

endpackage

/* rtl/stc27_ram.sv */
module stc27_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/stc27_mac.sv */
module stc27_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  stc27_pkg::tag_t      tag,
  input  stc27_pkg::taps_t     samples,
  input  stc27_pkg::taps_t     weights,
  output stc27_pkg::res_t      res
);

  logic signed [63:0] prod [stc27_pkg::TAPS];
  logic signed [65:0] sum9 [9];
  logic signed [67:0] sum3 [3];
  logic signed [69:0] total;
  logic signed [39:0] q;
  stc27_pkg::tag_t tag_p, tag_9, tag_3, tag_t4;

  assign q = 40'(total >>> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p.valid  <= 1'b0;
      tag_9.valid  <= 1'b0;
      tag_3.valid  <= 1'b0;
      tag_t4.valid <= 1'b0;
      res.valid    <= 1'b0;
    end else if (en) begin
      tag_p.valid  <= tag.valid;
      tag_9.valid  <= tag_p.valid;
      tag_3.valid  <= tag_9.valid;
      tag_t4.valid <= tag_3.valid;
      res.valid    <= tag_t4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_p.center_index  <= tag.center_index;
      tag_9.center_index  <= tag_p.center_index;
      tag_3.center_index  <= tag_9.center_index;
      tag_t4.center_index <= tag_3.center_index;
      res.center_index    <= tag_t4.center_index;
      for (int i = 0; i < stc27_pkg::TAPS; i++) begin
        prod[i] <= $signed(samples[i]) * $signed(weights[i]);
      end
      for (int j = 0; j < 9; j++) begin
        sum9[j] <= 66'(prod[3*j]) + 66'(prod[3*j+1]) + 66'(prod[3*j+2]);
      end
      for (int j = 0; j < 3; j++) begin
        sum3[j] <= 68'(sum9[3*j]) + 68'(sum9[3*j+1]) + 68'(sum9[3*j+2]);
      end
      total <= 70'(sum3[0]) + 70'(sum3[1]) + 70'(sum3[2]) + 70'sd536870912;
      if (q > 40'sd2147483647) begin
        res.result    <= 32'h7fffffff;
        res.saturated <= 1'b1;
      end else if (q < -40'sd2147483648) begin
        res.result    <= 32'h80000000;
        res.saturated <= 1'b1;
      end else begin
        res.result    <= q[31:0];
        res.saturated <= 1'b0;
      end
    end
  end

endmodule

/* rtl/stencil_27_point_3d_top.sv */
// 27-point 3D stencil over a grid streamed in linear order. Weight loads (tuser bit 0 high)
// and grid samples share the input stream; each sample whose neighbourhood is complete
// yields one result through the memory read stage and the MAC's product, sum9, sum3, total
// and result registers. Steady throughput is one transaction per cycle while not stalled:
// eight copies of the sample history, one per neighbour row except the newest, are read in
// parallel; the newest row comes from the incoming samples, and the two older taps of each
// row come from shift registers. After reset and after any configuration write the block
// refills those taps from memory, with s_tready low. Output backpressure stalls the whole pipeline.
module stencil_27_point_3d_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // weight_slot[4:0], value[36:5], zero pad
  input  logic [1:0]  s_tuser,   // command[0], start_of_grid[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // center_index[31:0], result[63:32], saturated[64], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = stc27_pkg::ADDR_W;

  logic [8:0]  row_length;
  logic [16:0] plane_size;
  logic [8:0]  r;
  logic [16:0] p;
  logic [17:0] a;
  logic        en, accept, smp, ld, prime_step, re, primed, prime_cnt, emit;
  logic [1:0]  off;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] fill, fill_base, fill_new;
  logic [31:0] seen, seen_new;
  logic [4:0]  slot;
  logic [31:0] value;
  stc27_pkg::word_t weights [stc27_pkg::TAPS];
  stc27_pkg::taps_t w_vec, s_vec;
  logic [AW-1:0] raddr [stc27_pkg::MEM_ROWS];
  logic [31:0] dout [stc27_pkg::MEM_ROWS];
  logic [31:0] tap1 [stc27_pkg::MEM_ROWS];
  logic [31:0] tap2 [stc27_pkg::MEM_ROWS];
  logic [31:0] samp1, samp2, sample1;
  logic        valid1, shonly1, emit1;
  logic [31:0] center1;
  stc27_pkg::tag_t tag;
  stc27_pkg::res_t res;

  assign slot  = s_tdata[4:0];
  assign value = s_tdata[36:5];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 9'd34;
      plane_size <= 17'd1156;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        stc27_pkg::REG_ROW_LENGTH: row_length <= pwdata[8:0];
        stc27_pkg::REG_PLANE_SIZE: plane_size <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      stc27_pkg::REG_ROW_LENGTH: prdata = {23'd0, row_length};
      stc27_pkg::REG_PLANE_SIZE: prdata = {15'd0, plane_size};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    r = row_length;
    if (row_length < 9'(stc27_pkg::MIN_ROW)) r = 9'(stc27_pkg::MIN_ROW);
    if (row_length > 9'(stc27_pkg::MAX_ROW)) r = 9'(stc27_pkg::MAX_ROW);
    p = plane_size;
    if (plane_size < 17'(stc27_pkg::MIN_PLANE)) p = 17'(stc27_pkg::MIN_PLANE);
    if (plane_size > 17'(stc27_pkg::MAX_PLANE)) p = 17'(stc27_pkg::MAX_PLANE);
    a = 18'(p) + 18'(r) + 18'd1;
  end

  assign en         = !m_tvalid || m_tready;
  assign s_tready   = en && primed;
  assign accept     = s_tvalid && s_tready;
  assign smp        = accept && (s_tuser[0] == stc27_pkg::CMD_SAMPLE);
  assign ld         = accept && (s_tuser[0] == stc27_pkg::CMD_LOAD);
  assign prime_step = en && !primed;
  assign re         = smp || prime_step;
  assign off        = primed ? 2'd0 : (prime_cnt ? 2'd1 : 2'd2);

  assign fill_base = s_tuser[1] ? '0 : fill;
  assign fill_new  = (fill_base == AW'(stc27_pkg::HIST_DEPTH)) ? fill_base : fill_base + 1'b1;
  assign seen_new  = (s_tuser[1] ? 32'd0 : seen) + 32'd1;
  assign emit      = {1'b0, fill_new} >= ({a, 1'b0} + 19'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      prime_cnt <= 1'b0;
      wr_ptr    <= '0;
      fill      <= '0;
      seen      <= '0;
      valid1    <= 1'b0;
      for (int i = 0; i < stc27_pkg::TAPS; i++) begin
        weights[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        primed    <= 1'b0;
        prime_cnt <= 1'b0;
      end else if (prime_step) begin
        prime_cnt <= !prime_cnt;
        primed    <= prime_cnt;
      end
      if (ld && slot < 5'(stc27_pkg::TAPS)) begin
        weights[slot] <= value;
      end
      if (smp) begin
        wr_ptr <= (wr_ptr == AW'(stc27_pkg::HIST_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        fill   <= fill_new;
        seen   <= seen_new;
      end
      if (en) begin
        valid1 <= re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shonly1 <= prime_step;
      emit1   <= smp && emit;
      center1 <= seen_new - 32'd1 - 32'(a);
      sample1 <= value;
      if (valid1) begin
        for (int k = 0; k < stc27_pkg::MEM_ROWS; k++) begin
          tap1[k] <= dout[k];
          tap2[k] <= tap1[k];
        end
        if (!shonly1) begin
          samp1 <= sample1;
          samp2 <= samp1;
        end
      end
    end
  end

  for (genvar k = 0; k < stc27_pkg::MEM_ROWS; k++) begin : g_row
    localparam int DZ = k / 3 - 1;
    localparam int DY = k % 3 - 1;
    logic [18:0] age;
    always_comb begin
      age = 19'(a) - 19'd1 + 19'(off);
      if (DY < 0) age = age + 19'(r);
      if (DY > 0) age = age - 19'(r);
      if (DZ < 0) age = age + 19'(p);
      if (DZ > 0) age = age - 19'(p);
      if ({1'b0, wr_ptr} >= age) begin
        raddr[k] = AW'({1'b0, wr_ptr} - age);
      end else begin
        raddr[k] = AW'({1'b0, wr_ptr} + 19'(stc27_pkg::HIST_DEPTH) - age);
      end
    end
    stc27_ram #(.WIDTH(32), .DEPTH(stc27_pkg::HIST_DEPTH)) u_hist (
      .clk   (clk),
      .we    (smp),
      .waddr (wr_ptr),
      .wdata (value),
      .re    (re),
      .raddr (raddr[k]),
      .rdata (dout[k])
    );
    assign s_vec[3*k+2] = dout[k];
    assign s_vec[3*k+1] = tap1[k];
    assign s_vec[3*k]   = tap2[k];
  end

  assign s_vec[26] = sample1;
  assign s_vec[25] = samp1;
  assign s_vec[24] = samp2;

  always_comb begin
    for (int i = 0; i < stc27_pkg::TAPS; i++) begin
      w_vec[i] = weights[i];
    end
  end

  assign tag.valid        = valid1 && emit1;
  assign tag.center_index = center1;

  stc27_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag     (tag),
    .samples (s_vec),
    .weights (w_vec),
    .res     (res)
  );

  assign m_tvalid = res.valid;
  assign m_tdata  = {7'd0, res.saturated, res.result, res.center_index};

endmodule

/* rtl/stc27_checker.sv */
module stc27_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[63:32] == 32'h7fffffff ||
                                m_tdata[63:32] == 32'h80000000)
    else $error("saturated flag without clipped value");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !s_tready)
    else $error("input taken before tap refill");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind stencil_27_point_3d_top stc27_checker u_stc27_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite)
);

/* tb/tb_stencil_27_point_3d_top.sv */
`timescale 1ns / 100ps

module tb_stencil_27_point_3d_top;

  typedef struct {
    logic        cmd;
    logic        sog;
    logic [4:0]  slot;
    logic [31:0] value;
  } stim_t;

  typedef struct {
    logic [31:0] center_index;
    logic [31:0] result;
    logic        saturated;
  } stencil_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // weight_slot[4:0], value[36:5], zero pad
  logic [1:0]  s_tuser = '0;   // command[0], start_of_grid[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // center_index[31:0], result[63:32], saturated[64], zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stencil_27_point_3d_top dut (.*);

  always #6 clk = ~clk;

  stim_t        pending_q[$];
  stencil_out_t expected_q[$];
  stim_t        cur_item;

  logic [31:0] history[stc27_pkg::HIST_DEPTH];
  logic [31:0] weights[stc27_pkg::TAPS];
  logic [31:0] seen_cnt;
  int          wr_ptr;
  int          fill_cnt;
  logic [8:0]  row_reg;
  logic [16:0] plane_reg;

  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int sat_seen = 0;
  longint cycles = 0;
  int s_idle_pct;
  int m_idle_pct;

  always @* begin
    if (accepted < 250) begin
      s_idle_pct = 8;
      m_idle_pct = 56;
    end else if (accepted < 500) begin
      s_idle_pct = 56;
      m_idle_pct = 8;
    end else begin
      s_idle_pct = 0;
      m_idle_pct = 0;
    end
  end

  task automatic stencil_step(input stim_t it);
    int r, p, a, d, age, pos;
    logic signed [63:0]  prod;
    logic signed [127:0] acc;
    logic signed [127:0] q;
    stencil_out_t e;
    if (it.cmd == stc27_pkg::CMD_LOAD) begin
      if (it.slot < stc27_pkg::TAPS) weights[it.slot] = it.value;
      return;
    end
    if (it.sog) begin
      seen_cnt = 0;
      fill_cnt = 0;
    end
    history[wr_ptr] = it.value;
    seen_cnt = seen_cnt + 1;
    if (fill_cnt < stc27_pkg::HIST_DEPTH) fill_cnt++;
    r = row_reg;
    if (r < stc27_pkg::MIN_ROW) r = stc27_pkg::MIN_ROW;
    if (r > stc27_pkg::MAX_ROW) r = stc27_pkg::MAX_ROW;
    p = plane_reg;
    if (p < stc27_pkg::MIN_PLANE) p = stc27_pkg::MIN_PLANE;
    if (p > stc27_pkg::MAX_PLANE) p = stc27_pkg::MAX_PLANE;
    a = p + r + 1;
    if (fill_cnt >= 2 * a + 1) begin
      acc = '0;
      for (int dz = -1; dz <= 1; dz++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++) begin
            d = dx + dy * r + dz * p;
            age = a - d;
            pos = (wr_ptr + stc27_pkg::HIST_DEPTH - age) % stc27_pkg::HIST_DEPTH;
            prod = longint'($signed(history[pos])) *
                   longint'($signed(weights[9 * (dz + 1) + 3 * (dy + 1) + dx + 1]));
            acc = acc + {{64{prod[63]}}, prod};
          end
      q = (acc + (128'sd1 <<< 29)) >>> 30;
      e.saturated = 1'b1;
      if (q > 128'sd2147483647) e.result = 32'h7FFF_FFFF;
      else if (q < -128'sd2147483648) e.result = 32'h8000_0000;
      else begin
        e.result = q[31:0];
        e.saturated = 1'b0;
      end
      e.center_index = seen_cnt - 1 - a;
      expected_q.push_back(e);
    end
    wr_ptr = (wr_ptr + 1 == stc27_pkg::HIST_DEPTH) ? 0 : wr_ptr + 1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        stencil_step(cur_item);
        accepted++;
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
        cur_item = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, cur_item.value, cur_item.slot};
        s_tuser  <= {cur_item.sog, cur_item.cmd};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stencil_out_t e;
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata[64]) sat_seen++;
          if (m_tdata[31:0] !== e.center_index) begin
            $display("%0t: center_index expected %h actual %h",
                     $time, e.center_index, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== e.result) begin
            $display("%0t: result expected %h actual %h", $time, e.result, m_tdata[63:32]);
            errors++;
          end
          if (m_tdata[64] !== e.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, e.saturated, m_tdata[64]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= m_idle_pct);
    end
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic stim_t load_item(input logic [4:0] slot, input logic [31:0] v);
    stim_t it;
    it.cmd = stc27_pkg::CMD_LOAD;
    it.sog = 1'($urandom_range(1));
    it.slot = slot;
    it.value = v;
    return it;
  endfunction

  function automatic stim_t sample_item(input logic sog, input logic [31:0] v);
    stim_t it;
    it.cmd = stc27_pkg::CMD_SAMPLE;
    it.sog = sog;
    it.slot = 5'($urandom);
    it.value = v;
    return it;
  endfunction

  task automatic drain();
    wait (pending_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == stc27_pkg::REG_ROW_LENGTH) row_reg = v[8:0];
    else plane_reg = v[16:0];
  endtask

  task automatic run_grid(input int r, input int p, input int extra);
    int n;
    n = 2 * (r + p + 1) + 1 + extra;
    pending_q.push_back(sample_item(1'b1, pick_value()));
    for (int i = 1; i < n; i++) begin
      if ($urandom_range(11) == 0)
        pending_q.push_back(load_item(5'($urandom), pick_value()));
      pending_q.push_back(sample_item($urandom_range(60) == 0, pick_value()));
    end
  endtask

  initial begin
    int r, p;
    foreach (weights[i]) weights[i] = '0;
    seen_cnt = 0;
    wr_ptr = 0;
    fill_cnt = 0;
    row_reg = 9'd34;
    plane_reg = 17'd1156;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extreme weights, ignored bad slots, start flag on a load
    for (int i = 0; i < stc27_pkg::TAPS; i++)
      pending_q.push_back(load_item(i[4:0], i[0] ? 32'h7FFF_FFFF : 32'h8000_0000));
    pending_q.push_back(load_item(5'd31, 32'h1234_5678));
    pending_q.push_back(load_item(5'd27, 32'hFFFF_FFFF));
    pending_q.push_back(sample_item(1'b1, 32'h7FFF_FFFF));
    pending_q.push_back(sample_item(1'b0, 32'h8000_0000));
    drain();

    // below-range sizes clamp to the smallest window
    write_reg(stc27_pkg::REG_ROW_LENGTH, 32'hFFFF_FE00);
    write_reg(stc27_pkg::REG_PLANE_SIZE, 32'h0000_0000);
    run_grid(3, 9, 8);
    drain();

    // above-range sizes clamp to the largest window; no output expected
    write_reg(stc27_pkg::REG_ROW_LENGTH, 32'h0000_01FF);
    write_reg(stc27_pkg::REG_PLANE_SIZE, 32'h0001_FFFF);
    for (int i = 0; i < 6; i++) pending_q.push_back(sample_item(i == 0, pick_value()));
    drain();

    while (accepted < 500) begin
      r = $urandom_range(3, 7);
      p = $urandom_range(9, 40);
      if ($urandom_range(3) == 0) r = stc27_pkg::MIN_ROW;
      write_reg(stc27_pkg::REG_ROW_LENGTH, r);
      write_reg(stc27_pkg::REG_PLANE_SIZE, p);
      for (int i = 0; i < stc27_pkg::TAPS; i++)
        if ($urandom_range(2) == 0)
          pending_q.push_back(load_item(i[4:0], $urandom_range(3) == 0 ? $urandom :
                                        $urandom_range(32'h07FF_FFFF) - 32'h0400_0000));
      run_grid(r, p, $urandom_range(10, 40));
      drain();
    end

    $display("Covered %0d transactions in, %0d results out (%0d saturated),",
             accepted, results_seen, sat_seen);
    $display("over clamped, extreme and random grid sizes with varied stalls.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stc27_pkg.sv
rtl/stc27_ram.sv
rtl/stc27_mac.sv
rtl/stencil_27_point_3d_top.sv
rtl/stc27_checker.sv
tb/tb_stencil_27_point_3d_top.sv
